### design/utf16_to_utf8_encoder_top_defines.svh
// assertion macros for the utf-16 to utf-8 encoder rtl, used by u16u8_back
// expects signals named clk and rst_n in the module that uses them
`ifndef UTF16_TO_UTF8_ENCODER_TOP_DEFINES_SVH
`define UTF16_TO_UTF8_ENCODER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define U8_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define U8_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/u16u8_pkg.sv
// package for the utf-16 to utf-8 encoder: job type, constants, byte encoder functions
// no dependencies
`default_nettype none

package u16u8_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] SURR_HIGH_MIN = 16'hD800;
    localparam logic [15:0] SURR_HIGH_MAX = 16'hDBFF;
    localparam logic [15:0] SURR_LOW_MIN  = 16'hDC00;
    localparam logic [15:0] SURR_LOW_MAX  = 16'hDFFF;
    localparam logic [20:0] PAIR_BASE     = 21'h10000;

    localparam logic [20:0] CP_LIMIT_1B = 21'h80;
    localparam logic [20:0] CP_LIMIT_2B = 21'h800;
    localparam logic [20:0] CP_LIMIT_3B = 21'h10000;

    localparam logic [1:0] CONT_TAG = 2'b10;
    localparam logic [2:0] LEAD_2B  = 3'b110;
    localparam logic [3:0] LEAD_3B  = 4'b1110;
    localparam logic [4:0] LEAD_4B  = 5'b11110;

    // one unit of work for the back end: one or two code points
    typedef struct packed {
        logic [20:0] cp_a;
        logic        has_b;
        logic [20:0] cp_b;
    } job_t;

    // number of utf-8 bytes minus one
    function automatic logic [1:0] enc_len_m1(input logic [20:0] cp);
        logic [1:0] len;
        if (cp < CP_LIMIT_1B)
        begin
            len = 2'd0;
        end
        else if (cp < CP_LIMIT_2B)
        begin
            len = 2'd1;
        end
        else if (cp < CP_LIMIT_3B)
        begin
            len = 2'd2;
        end
        else
        begin
            len = 2'd3;
        end
        return len;
    endfunction

    // byte idx of the utf-8 sequence for cp
    function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] idx);
        logic [1:0] len_m1;
        logic [1:0] rem;
        logic [7:0] b;
        len_m1 = enc_len_m1(cp);
        rem    = len_m1 - idx;
        if (idx == 2'd0)
        begin
            case (len_m1)
                2'd0:    b = {1'b0, cp[6:0]};
                2'd1:    b = {LEAD_2B, cp[10:6]};
                2'd2:    b = {LEAD_3B, cp[15:12]};
                default: b = {LEAD_4B, cp[20:18]};
            endcase
        end
        else
        begin
            case (rem)
                2'd0:    b = {CONT_TAG, cp[5:0]};
                2'd1:    b = {CONT_TAG, cp[11:6]};
                default: b = {CONT_TAG, cp[17:12]};
            endcase
        end
        return b;
    endfunction

endpackage

`default_nettype wire

### design/u16u8_ifs.sv
// channel interfaces for the encoder: code units in, utf-8 bytes out
// no dependencies
`default_nettype none

interface u16u8_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        end_of_string;

    modport source (output valid, output code_unit, output end_of_string, input ready);
    modport sink   (input valid, input code_unit, input end_of_string, output ready);
endinterface

interface u16u8_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] utf8_byte;
    logic       last_of_run;

    modport source (output valid, output utf8_byte, output last_of_run, input ready);
    modport sink   (input valid, input utf8_byte, input last_of_run, output ready);
endinterface

`default_nettype wire

### design/u16u8_front.sv
// front end: accepts code units, tracks a held high surrogate, builds jobs
// depends on u16u8_pkg and u16u8_unit_if
`default_nettype none

module u16u8_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    u16u8_unit_if.sink          units,
    input  wire logic           q_full,
    output u16u8_pkg::job_t     job,
    output logic                push
);

    logic       pending_reg;
    logic       pending_next;
    logic [9:0] held_reg;
    logic [9:0] held_next;
    logic       accept;
    logic       is_high;
    logic       is_low;
    logic       hold_now;

    assign units.ready = !q_full;
    assign accept      = units.valid && units.ready;

    assign is_high  = (units.code_unit >= u16u8_pkg::SURR_HIGH_MIN)
                   && (units.code_unit <= u16u8_pkg::SURR_HIGH_MAX);
    assign is_low   = (units.code_unit >= u16u8_pkg::SURR_LOW_MIN)
                   && (units.code_unit <= u16u8_pkg::SURR_LOW_MAX);
    // a pair completes only when a low follows a held high
    assign hold_now = is_high && !units.end_of_string && !(pending_reg && is_low);

    always_comb
    begin
        job          = '0;
        push         = 1'b0;
        pending_next = pending_reg;
        held_next    = held_reg;
        if (pending_reg && is_low)
        begin
            job.cp_a = u16u8_pkg::PAIR_BASE + 21'({held_reg, units.code_unit[9:0]});
        end
        else if (pending_reg)
        begin
            // flush lone high surrogate, then the current unit unless it is held
            job.cp_a  = 21'({6'b110110, held_reg});
            job.has_b = !hold_now;
            job.cp_b  = 21'(units.code_unit);
        end
        else
        begin
            job.cp_a = 21'(units.code_unit);
        end
        if (accept)
        begin
            push         = pending_reg || !hold_now;
            pending_next = hold_now;
            held_next    = hold_now ? units.code_unit[9:0] : 10'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            held_reg    <= 10'd0;
        end
        else
        begin
            pending_reg <= pending_next;
            held_reg    <= held_next;
        end
    end

endmodule

`default_nettype wire

### design/u16u8_queue.sv
// short job queue between front and back end
// depends on u16u8_pkg
`default_nettype none

module u16u8_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire u16u8_pkg::job_t wr_job,
    input  wire logic           pop,
    output u16u8_pkg::job_t     rd_job,
    output logic                full,
    output logic                empty
);

    localparam int DEPTH = u16u8_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u16u8_pkg::job_t    slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_job  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### design/u16u8_back.sv
// back end: walks the head job byte by byte into a registered output stage
// depends on u16u8_pkg, u16u8_byte_if and the assertion macro header
`default_nettype none
`include "utf16_to_utf8_encoder_top_defines.svh"

module u16u8_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    u16u8_byte_if.source        octets,
    input  wire u16u8_pkg::job_t head,
    input  wire logic           head_valid,
    output logic                pop
);

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       out_last_reg;
    logic       out_last_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       sel_reg;
    logic       sel_next;
    logic [20:0] cur_cp;
    logic [1:0] len_m1;
    logic       load;
    logic       cp_done;
    logic       job_done;

    assign cur_cp   = sel_reg ? head.cp_b : head.cp_a;
    assign len_m1   = u16u8_pkg::enc_len_m1(cur_cp);
    assign cp_done  = (idx_reg == len_m1);
    assign job_done = cp_done && (sel_reg || !head.has_b);
    assign load     = head_valid && (!out_valid_reg || octets.ready);
    assign pop      = load && job_done;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        idx_next       = idx_reg;
        sel_next       = sel_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = u16u8_pkg::enc_byte(cur_cp, idx_reg);
            out_last_next  = job_done;
            if (cp_done)
            begin
                idx_next = 2'd0;
                sel_next = !job_done;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
        else if (octets.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            sel_reg       <= sel_next;
        end
    end

    assign octets.valid       = out_valid_reg;
    assign octets.utf8_byte   = out_byte_reg;
    assign octets.last_of_run = out_last_reg;

    `U8_ASSERT_IMP(a_idx_in_range, head_valid, idx_reg <= len_m1,
        "byte index past end of code point")
    `U8_ASSERT_IMP(a_sel_has_b, sel_reg, head_valid && head.has_b,
        "second code point selected without one in the job")
    `U8_ASSERT_NXT(a_job_restart, load && job_done, idx_reg == 2'd0 && !sel_reg,
        "walk not rewound after job end")

endmodule

`default_nettype wire

### design/utf16_to_utf8_encoder_top.sv
// top level of the utf-16 to utf-8 encoder
// depends on u16u8_pkg, u16u8_ifs, u16u8_front, u16u8_queue, u16u8_back
//
//   channel   dir   payload                          handshake
//   units     in    code_unit[15:0], end_of_string   valid/ready
//   octets    out   utf8_byte[7:0], last_of_run      valid/ready
//
// the back end sends one utf-8 byte per cycle while a job is queued and octets
// is not stalled; a code unit yields 1 to 4 bytes, up to 6 when a lone high
// surrogate is flushed; a held high surrogate yields no byte.
// rst_n clears the held surrogate, the queue and the output stage at once.
// the front stalls only on a full job queue; the back stalls on octets.ready.
`default_nettype none

module utf16_to_utf8_encoder_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    u16u8_unit_if.sink      units,
    u16u8_byte_if.source    octets
);

    u16u8_pkg::job_t    wr_job;
    u16u8_pkg::job_t    head_job;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;

    // classify units, pair surrogates, hand jobs to the queue
    u16u8_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .units  (units),
        .q_full (q_full),
        .job    (wr_job),
        .push   (push)
    );

    // decouples unit intake from byte emission
    u16u8_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (head_job),
        .full   (q_full),
        .empty  (q_empty)
    );

    // serialize code points into utf-8 bytes
    u16u8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .octets     (octets),
        .head       (head_job),
        .head_valid (!q_empty),
        .pop        (pop)
    );

endmodule

`default_nettype wire

### sim/u16u8_stream_checker.sv
// stream checker for the utf-16 to utf-8 encoder: predicts the byte stream
// from observed code unit transfers and compares each byte transfer against it
// depends on u16u8_pkg for the surrogate range constants and PAIR_BASE
module u16u8_stream_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        unit_valid,
    input  wire logic        unit_ready,
    input  wire logic [15:0] code_unit,
    input  wire logic        end_of_string,
    input  wire logic        octet_valid,
    input  wire logic        octet_ready,
    input  wire logic [7:0]  utf8_byte,
    input  wire logic        last_of_run,
    output int               fail_count,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } octet_t;

    octet_t     expected_octets[$];
    logic [9:0] held_bits;
    logic       high_held;
    int         errors;

    function automatic int octet_count(input logic [20:0] cp);
        int len;
        if (cp < 21'h80)
        begin
            len = 1;
        end
        else if (cp < 21'h800)
        begin
            len = 2;
        end
        else if (cp < 21'h10000)
        begin
            len = 3;
        end
        else
        begin
            len = 4;
        end
        return len;
    endfunction

    function automatic logic [7:0] octet_value(input logic [20:0] cp, input int len, input int k);
        logic [31:0] v;
        logic [31:0] r;
        v = {11'd0, cp};
        if (k == 0)
        begin
            case (len)
                1:       r = v;
                2:       r = 32'hC0 | (v >> 6);
                3:       r = 32'hE0 | (v >> 12);
                default: r = 32'hF0 | (v >> 18);
            endcase
        end
        else
        begin
            r = 32'h80 | ((v >> (6 * (len - 1 - k))) & 32'h3F);
        end
        return r[7:0];
    endfunction

    task automatic append_point(input logic [20:0] cp, inout int produced);
        int len;
        octet_t o;
        len = octet_count(cp);
        for (int k = 0; k < len; k++)
        begin
            o.value = octet_value(cp, len, k);
            o.last  = 1'b0;
            expected_octets.push_back(o);
            produced++;
        end
    endtask

    task automatic predict_unit(input logic [15:0] cu, input logic eos);
        logic   is_high;
        logic   is_low;
        int     produced;
        octet_t tail;
        is_high  = (cu >= u16u8_pkg::SURR_HIGH_MIN) && (cu <= u16u8_pkg::SURR_HIGH_MAX);
        is_low   = (cu >= u16u8_pkg::SURR_LOW_MIN) && (cu <= u16u8_pkg::SURR_LOW_MAX);
        produced = 0;
        if (high_held && is_low)
        begin
            append_point(u16u8_pkg::PAIR_BASE + {1'b0, held_bits, cu[9:0]}, produced);
            high_held = 1'b0;
            held_bits = '0;
        end
        else
        begin
            // a held high surrogate without its partner goes out alone first
            if (high_held)
            begin
                append_point({5'd0, 6'b110110, held_bits}, produced);
                high_held = 1'b0;
                held_bits = '0;
            end
            if (is_high && !eos)
            begin
                held_bits = cu[9:0];
                high_held = 1'b1;
            end
            else
            begin
                append_point({5'd0, cu}, produced);
            end
        end
        if (produced > 0)
        begin
            tail = expected_octets.pop_back();
            tail.last = 1'b1;
            expected_octets.push_back(tail);
        end
    endtask

    task automatic check_octet(input logic [7:0] got_value, input logic got_last);
        octet_t want;
        if (expected_octets.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected byte transfer, expected none actual %02h last %0b",
                $time, got_value, got_last);
        end
        else
        begin
            want = expected_octets.pop_front();
            if (want.value !== got_value)
            begin
                errors++;
                $display("%0t: utf8_byte mismatch, expected %02h actual %02h",
                    $time, want.value, got_value);
            end
            if (want.last !== got_last)
            begin
                errors++;
                $display("%0t: last_of_run mismatch, expected %0b actual %0b",
                    $time, want.last, got_last);
            end
        end
    endtask

    // bytes are checked before the unit of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_octets.delete();
            held_bits = '0;
            high_held = 1'b0;
            errors = 0;
            fail_count <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (octet_valid && octet_ready)
            begin
                check_octet(utf8_byte, last_of_run);
            end
            if (unit_valid && unit_ready)
            begin
                predict_unit(code_unit, end_of_string);
            end
            fail_count <= errors;
            outstanding <= expected_octets.size();
        end
    end

endmodule

### sim/utf16_to_utf8_encoder_top_tb.sv
// testbench top for the utf-16 to utf-8 encoder: clock, reset, code unit
// stimulus and byte-side backpressure; the stream checker does the comparing
// depends on u16u8_pkg, u16u8_ifs, utf16_to_utf8_encoder_top, u16u8_stream_checker
module utf16_to_utf8_encoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIRECTED_COUNT = 28;
    localparam int RANDOM_UNITS   = 410;
    localparam int DRAIN_CYCLES   = 20;
    localparam int LIMIT_NS       = 3_000_000;

    // directed units as {end_of_string, code_unit}
    localparam logic [16:0] DIRECTED [DIRECTED_COUNT] = '{
        {1'b0, 16'h0000}, {1'b0, 16'h007F}, {1'b0, 16'h0080}, {1'b0, 16'h07FF},
        {1'b0, 16'h0800}, {1'b0, 16'hD7FF}, {1'b0, 16'hE000}, {1'b0, 16'hFFFF},
        // lowest and highest surrogate pairs
        {1'b0, 16'hD800}, {1'b0, 16'hDC00}, {1'b0, 16'hDBFF}, {1'b0, 16'hDFFF},
        // lone low surrogates
        {1'b0, 16'hDC00}, {1'b0, 16'hDFFF},
        // lone high flushed ahead of a three-byte unit: six bytes in one run
        {1'b0, 16'hD801}, {1'b0, 16'hFFFF},
        // lone high flushed ahead of ascii
        {1'b0, 16'hDBFF}, {1'b0, 16'h0041},
        // high then high then low: first flushed, second paired
        {1'b0, 16'hD800}, {1'b0, 16'hDBFF}, {1'b0, 16'hDC05},
        // high surrogate that ends the string is not held
        {1'b1, 16'hDBFF},
        // held high paired with the final unit
        {1'b0, 16'hD834}, {1'b1, 16'hDD1E},
        // held high flushed before a final non-surrogate
        {1'b0, 16'hD800}, {1'b1, 16'h007F},
        // held high flushed before a final high surrogate
        {1'b0, 16'hDABC}, {1'b1, 16'hDB00}
    };

    logic clk;
    logic rst_n;

    // channels between testbench and block
    u16u8_unit_if units_ch ();
    u16u8_byte_if octets_ch ();

    int fail_count;
    int outstanding;
    int units_issued;
    logic calm;

    utf16_to_utf8_encoder_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .units  (units_ch),
        .octets (octets_ch)
    );

    // watches both channels, predicts and compares
    u16u8_stream_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .unit_valid    (units_ch.valid),
        .unit_ready    (units_ch.ready),
        .code_unit     (units_ch.code_unit),
        .end_of_string (units_ch.end_of_string),
        .octet_valid   (octets_ch.valid),
        .octet_ready   (octets_ch.ready),
        .utf8_byte     (octets_ch.utf8_byte),
        .last_of_run   (octets_ch.last_of_run),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // hard stop in case the handshake hangs
    initial
    begin
        #(LIMIT_NS);
        $display("utf16_to_utf8_encoder_top regression: fail");
        $finish;
    end

    // idle length between unit transfers: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
        begin
            gap = 0;
        end
        else if (r < 88)
        begin
            gap = $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            gap = $urandom_range(4, 12);
        end
        else
        begin
            gap = $urandom_range(20, 50);
        end
        return gap;
    endfunction

    // one unit transfer; valid stays high across back-to-back transfers
    task automatic send_unit(input logic [15:0] cu, input logic eos);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            // junk payload while idle
            units_ch.valid         <= 1'b0;
            units_ch.code_unit     <= 16'($urandom());
            units_ch.end_of_string <= 1'($urandom());
            repeat (gap) @(posedge clk);
        end
        units_ch.valid         <= 1'b1;
        units_ch.code_unit     <= cu;
        units_ch.end_of_string <= eos;
        @(posedge clk);
        while (!units_ch.ready)
        begin
            @(posedge clk);
        end
        units_issued++;
    endtask

    // byte-side backpressure: runs of ready high, short stalls, rare long stalls
    initial
    begin
        logic level;
        int run_left;
        int r;
        level = 1'b0;
        run_left = 0;
        octets_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (calm)
            begin
                level = 1'b1;
                run_left = 0;
            end
            else if (run_left > 0)
            begin
                run_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                begin
                    level = 1'b1;
                    run_left = $urandom_range(0, 6);
                end
                else if (r < 95)
                begin
                    level = 1'b0;
                    run_left = $urandom_range(0, 3);
                end
                else
                begin
                    level = 1'b0;
                    run_left = $urandom_range(10, 40);
                end
            end
            octets_ch.ready <= level;
        end
    end

    // reset, directed units, random strings, drain and verdict
    initial
    begin
        int n_units;
        int kind;
        logic last;
        units_ch.valid = 1'b0;
        units_ch.code_unit = '0;
        units_ch.end_of_string = 1'b0;
        units_issued = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            send_unit(DIRECTED[i][15:0], DIRECTED[i][16]);
        end

        while (units_issued < DIRECTED_COUNT + RANDOM_UNITS)
        begin
            // now and then a whole string with no idling on either side
            calm = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 9) < 8)
            begin
                // well-formed string of random characters, eos on the final unit
                n_units = $urandom_range(1, 8);
                for (int c = 0; c < n_units; c++)
                begin
                    last = (c == n_units - 1);
                    kind = $urandom_range(0, 9);
                    if (kind < 3)
                    begin
                        send_unit(16'($urandom_range(16'h0000, 16'h007F)), last);
                    end
                    else if (kind < 5)
                    begin
                        send_unit(16'($urandom_range(16'h0080, 16'h07FF)), last);
                    end
                    else if (kind < 7)
                    begin
                        if ($urandom_range(0, 1) == 0)
                        begin
                            send_unit(16'($urandom_range(16'h0800, 16'hD7FF)), last);
                        end
                        else
                        begin
                            send_unit(16'($urandom_range(16'hE000, 16'hFFFF)), last);
                        end
                    end
                    else
                    begin
                        send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
                        send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), last);
                    end
                end
            end
            else
            begin
                // broken sequence: raw values and lone surrogates, eos anywhere
                n_units = $urandom_range(1, 6);
                for (int c = 0; c < n_units; c++)
                begin
                    kind = $urandom_range(0, 9);
                    last = ($urandom_range(0, 3) == 0);
                    if (kind < 3)
                    begin
                        send_unit(16'($urandom()), last);
                    end
                    else if (kind < 6)
                    begin
                        send_unit(16'($urandom_range(16'hD800, 16'hDBFF)), last);
                    end
                    else if (kind < 8)
                    begin
                        send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), last);
                    end
                    else
                    begin
                        send_unit(16'($urandom_range(16'h0000, 16'h007F)), last);
                    end
                end
            end
        end
        units_ch.valid <= 1'b0;
        calm = 1'b0;

        // the checker's counts are registered, so they lag the transfers
        repeat (2) @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        if (fail_count == 0)
        begin
            $display("utf16_to_utf8_encoder_top regression: pass");
        end
        else
        begin
            $display("utf16_to_utf8_encoder_top regression: fail");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/u16u8_pkg.sv
design/u16u8_ifs.sv
design/u16u8_front.sv
design/u16u8_queue.sv
design/u16u8_back.sv
design/utf16_to_utf8_encoder_top.sv
sim/u16u8_stream_checker.sv
sim/utf16_to_utf8_encoder_top_tb.sv
